// ===== rtl/moving_window_deconvolution_core_defines.svh =====
// assertion macros used by the moving window deconvolution back end
`ifndef MOVING_WINDOW_DECONVOLUTION_CORE_DEFINES_SVH
`define MOVING_WINDOW_DECONVOLUTION_CORE_DEFINES_SVH

// property must hold at every rising clock edge outside reset
`define DECONV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition must never be seen outside reset
`define DECONV_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== rtl/mwdc_pkg.sv =====
// shared constants and types of the moving window deconvolution core
package deconv_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int TOTAL_BITS     = 60;
   localparam int SEEN_BITS      = 12;
   localparam int DECAY_BITS     = 17;
   localparam int LEN_BITS       = 11;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;
   localparam int DIV_CNT_BITS   = 6;

   localparam logic [SEEN_BITS-1:0]      SEEN_MAX    = 12'd4095;
   localparam logic [DIV_CNT_BITS-1:0]   DIV_LAST    = 6'(TOTAL_BITS - 1);
   localparam logic [DECAY_BITS-1:0]     DECAY_RESET = 17'd65536;
   localparam logic [LEN_BITS-1:0]       LEN_RESET   = 11'd1;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECAY  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW = 2'd2;

   // per-item classification made by the front
   typedef struct packed {
      logic first;      // start of waveform, clears window total
      logic has_diff;   // enough samples for a difference
      logic drop_old;   // oldest difference leaves the window
      logic emit;       // a result is produced
   } item_flags_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_CALC,
      BK_DIV,
      BK_SEND
   } back_state_type;

endpackage

// ===== rtl/mwdc_ifs.sv =====
// request and response channel interfaces
interface deconv_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_value;
   logic                          first_of_waveform;
   modport source (output valid, sample_value, first_of_waveform, input ready);
   modport sink (input valid, sample_value, first_of_waveform, output ready);
endinterface

interface deconv_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                             valid;
   logic                             ready;
   logic signed [SAMPLE_BITS+32:0]   filtered_value;
   modport source (output valid, filtered_value, input ready);
   modport sink (input valid, filtered_value, output ready);
endinterface

// ===== rtl/mwdc_queue.sv =====
// small fifo between front and back
module deconv_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             valid
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/mwdc_front.sv =====
// front: accepts samples, runs the recursive deconvolution, classifies items
module deconv_front import deconv_pkg::*; #(
   parameter int MAX_OFFSET  = 1024,
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int QW          = 90
) (
   input  logic                  clock,
   input  logic                  reset,
   deconv_req_if.sink            req_if,
   input  logic [DECAY_BITS-1:0] decay,
   input  logic [LEN_BITS-1:0]   len_m,
   input  logic [LEN_BITS-1:0]   len_l,
   input  logic                  q_full,
   output logic                  q_push,
   output logic [QW-1:0]         q_data
);
   localparam int AB  = SAMPLE_BITS + 32;
   localparam int WB  = AB + 3;
   localparam int PB  = SAMPLE_BITS + 18;
   localparam int OW  = $clog2(MAX_OFFSET);
   localparam int FW  = $clog2(MAX_WINDOW);
   localparam int OCW = ((OW > LEN_BITS) ? OW : LEN_BITS) + 1;
   localparam int FCW = ((FW > LEN_BITS) ? FW : LEN_BITS) + 1;

   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in, prev_base;
   logic signed [AB-1:0]          acc_ff, acc_in, acc_base, acc_sat;
   logic [SEEN_BITS-1:0]          seen_ff, seen_in, n, ml;
   logic [OW-1:0]                 dpos_ff, dpos_in, dpos, drd;
   logic [FW-1:0]                 fpos_ff, fpos_in, fpos, frd;
   logic [OCW-1:0]                drd_w;
   logic [FCW-1:0]                frd_w;
   logic signed [PB-1:0]          prod;
   logic signed [WB-1:0]          sum;
   logic                          accept, first;
   item_flags_type                flags;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;
   assign first        = req_if.first_of_waveform;

   always_comb begin
      n         = first ? '0 : seen_ff;
      prev_base = first ? '0 : prev_ff;
      acc_base  = first ? '0 : acc_ff;
      dpos      = first ? '0 : dpos_ff;
      fpos      = first ? '0 : fpos_ff;

      // x*1.0 - f*prev_x + prev_A, then saturate to the accumulator range
      prod = PB'($signed({1'b0, decay})) * PB'(prev_base);
      sum  = (WB'(req_if.sample_value) <<< FRAC_BITS) - WB'(prod) + WB'(acc_base);
      if (sum[WB-1:AB-1] == '0 || sum[WB-1:AB-1] == '1) begin
         acc_sat = sum[AB-1:0];
      end else if (sum[WB-1]) begin
         acc_sat = {1'b1, {(AB-1){1'b0}}};
      end else begin
         acc_sat = {1'b0, {(AB-1){1'b1}}};
      end

      ml             = SEEN_BITS'(len_m) + SEEN_BITS'(len_l);
      flags.first    = first;
      flags.has_diff = (n >= SEEN_BITS'(len_m));
      flags.drop_old = (n >= ml);
      flags.emit     = ((SEEN_BITS+1)'(n) + 1'b1 >= (SEEN_BITS+1)'(ml));

      // ring read positions, wrapped at the history depth
      if (OCW'(dpos) >= OCW'(len_m)) begin
         drd_w = OCW'(dpos) - OCW'(len_m);
      end else begin
         drd_w = OCW'(dpos) + OCW'(MAX_OFFSET) - OCW'(len_m);
      end
      if (FCW'(fpos) >= FCW'(len_l)) begin
         frd_w = FCW'(fpos) - FCW'(len_l);
      end else begin
         frd_w = FCW'(fpos) + FCW'(MAX_WINDOW) - FCW'(len_l);
      end
      drd = drd_w[OW-1:0];
      frd = frd_w[FW-1:0];

      prev_in = prev_ff;
      acc_in  = acc_ff;
      seen_in = seen_ff;
      dpos_in = dpos_ff;
      fpos_in = fpos_ff;
      if (accept) begin
         prev_in = req_if.sample_value;
         acc_in  = acc_sat;
         seen_in = (n < SEEN_MAX) ? n + 1'b1 : n;
         dpos_in = (dpos == OW'(MAX_OFFSET - 1)) ? '0 : dpos + 1'b1;
         if (flags.has_diff) begin
            fpos_in = (fpos == FW'(MAX_WINDOW - 1)) ? '0 : fpos + 1'b1;
         end else begin
            fpos_in = fpos;
         end
      end
   end

   assign q_push = accept;
   assign q_data = {flags, fpos, frd, dpos, drd, acc_sat};

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         acc_ff  <= '0;
         seen_ff <= '0;
         dpos_ff <= '0;
         fpos_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         acc_ff  <= acc_in;
         seen_ff <= seen_in;
         dpos_ff <= dpos_in;
         fpos_ff <= fpos_in;
      end
   end

endmodule

// ===== rtl/mwdc_back.sv =====
// back: history memories, window sum, serial divide and result register
`include "moving_window_deconvolution_core_defines.svh"
module deconv_back import deconv_pkg::*; #(
   parameter int MAX_OFFSET  = 1024,
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int QW          = 90
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  logic [QW-1:0]       q_data,
   output logic                q_pop,
   input  logic [LEN_BITS-1:0] len_l,
   deconv_rsp_if.source        rsp_if
);
   localparam int AB = SAMPLE_BITS + 32;
   localparam int DB = AB + 1;
   localparam int TB = TOTAL_BITS;
   localparam int RB = LEN_BITS + 1;
   localparam int OW = $clog2(MAX_OFFSET);
   localparam int FW = $clog2(MAX_WINDOW);

   back_state_type         state_ff, state_in;
   logic signed [AB-1:0]   a_ff, dly_ff;
   logic [OW-1:0]          drd_ff, dwr_ff;
   logic [FW-1:0]          frd_ff, fwr_ff;
   item_flags_type         flags_ff;
   logic signed [AB-1:0]   dmem [MAX_OFFSET];
   logic signed [DB-1:0]   fmem [MAX_WINDOW];
   logic signed [DB-1:0]   old_ff, d;
   logic signed [TB-1:0]   total_ff, base, t;
   logic [TB-1:0]          quo_ff, quo_in, res;
   logic [RB-1:0]          rem_ff, rem_in, shifted;
   logic                   neg_ff, ge;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic signed [DB-1:0]   out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (q_valid) state_in = BK_READ;
         BK_READ: state_in = BK_CALC;
         BK_CALC: begin
            if (flags_ff.has_diff && flags_ff.emit) state_in = BK_DIV;
            else state_in = BK_IDLE;
         end
         BK_DIV:  if (cnt_ff == DIV_LAST) state_in = BK_SEND;
         BK_SEND: if (rsp_if.ready) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop        = 1'b0;
      rsp_if.valid = 1'b0;
      unique case (state_ff)
         BK_IDLE: q_pop = q_valid;
         BK_SEND: rsp_if.valid = 1'b1;
         default: begin
            q_pop        = 1'b0;
            rsp_if.valid = 1'b0;
         end
      endcase
   end

   assign rsp_if.filtered_value = out_ff;

   always_comb begin
      d    = DB'(a_ff) - DB'(dly_ff);
      base = flags_ff.first ? '0 : total_ff;
      t    = base + TB'(d) - (flags_ff.drop_old ? TB'(old_ff) : TB'(0));
      // restoring divide, one quotient bit per cycle
      shifted = {rem_ff[RB-2:0], quo_ff[TB-1]};
      ge      = (shifted >= RB'(len_l));
      rem_in  = ge ? shifted - RB'(len_l) : shifted;
      quo_in  = {quo_ff[TB-2:0], ge};
      res     = neg_ff ? (~quo_in + 1'b1) : quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_CALC) begin
            total_ff <= flags_ff.has_diff ? t : base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         {flags_ff, fwr_ff, frd_ff, dwr_ff, drd_ff, a_ff} <= q_data;
      end
      if (state_ff == BK_READ) begin
         dly_ff <= dmem[drd_ff];
         old_ff <= fmem[frd_ff];
      end
      if (state_ff == BK_CALC) begin
         dmem[dwr_ff] <= a_ff;
         if (flags_ff.has_diff) begin
            fmem[fwr_ff] <= d;
         end
         rem_ff <= '0;
         cnt_ff <= '0;
         neg_ff <= t[TB-1];
         quo_ff <= t[TB-1] ? TB'(-t) : TB'(t);
      end
      if (state_ff == BK_DIV) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            out_ff <= res[DB-1:0];
         end
      end
   end

   `DECONV_NEVER(a_div_count, state_ff == BK_DIV && cnt_ff > DIV_LAST, "divide ran past its last step")
   `DECONV_NEVER(a_rem_bound, state_ff == BK_DIV && rem_ff >= RB'(len_l), "partial remainder not below window length")
   `DECONV_ASSERT(a_rsp_hold, state_ff == BK_SEND && !rsp_if.ready |=> state_ff == BK_SEND && $stable(out_ff), "stalled result changed")

endmodule

// ===== rtl/moving_window_deconvolution_core.sv =====
// moving window deconvolution filter, top level
// each sample beat runs through three stages: a recursive deconvolution
// A = x - f*prev_x + prev_A (Q32.16, saturating), a difference D = A - A
// from M samples back, and a moving average of the last L values of D,
// truncated toward zero. first_of_waveform clears the filter state; the
// first result of a waveform comes with sample M+L. the front accepts one
// sample beat per cycle while its two-entry queue has room. the back takes
// a sample without result through read and calc, one with a result also
// through the 60-step serial divide by L and a send state held by response
// stall, and no new sample before the last is done. the user must write
// configuration through the csr port only while the block is idle; the block
// does not enforce it. lengths are clamped to 1..MAX_OFFSET and 1..MAX_WINDOW.
module moving_window_deconvolution_core import deconv_pkg::*; #(
   parameter int MAX_OFFSET  = 1024,
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   deconv_req_if.sink                req_if,
   deconv_rsp_if.source              rsp_if,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);
   localparam int AB = SAMPLE_BITS + 32;
   localparam int OW = $clog2(MAX_OFFSET);
   localparam int FW = $clog2(MAX_WINDOW);
   localparam int QW = AB + 2 * OW + 2 * FW + $bits(item_flags_type);

   // configuration registers
   logic [DECAY_BITS-1:0] decay_ff;
   logic [LEN_BITS-1:0]   offset_ff, window_ff;
   logic [LEN_BITS-1:0]   len_m, len_l;

   // front to back queue
   logic          q_push, q_full, q_pop, q_valid;
   logic [QW-1:0] q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff  <= DECAY_RESET;
         offset_ff <= LEN_RESET;
         window_ff <= LEN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DECAY:  decay_ff  <= csr_write_data[DECAY_BITS-1:0];
            CSR_OFFSET: offset_ff <= csr_write_data[LEN_BITS-1:0];
            CSR_WINDOW: window_ff <= csr_write_data[LEN_BITS-1:0];
            default:    decay_ff  <= decay_ff;   // unused index, ignored
         endcase
      end
   end

   // zero acts as one, oversize values act as the history depth
   always_comb begin
      if (offset_ff == '0) begin
         len_m = LEN_BITS'(1);
      end else if (offset_ff > MAX_OFFSET) begin
         len_m = LEN_BITS'(MAX_OFFSET);
      end else begin
         len_m = offset_ff;
      end
      if (window_ff == '0) begin
         len_l = LEN_BITS'(1);
      end else if (window_ff > MAX_WINDOW) begin
         len_l = LEN_BITS'(MAX_WINDOW);
      end else begin
         len_l = window_ff;
      end
   end

   // front: accept, stage one, classification
   deconv_front #(
      .MAX_OFFSET  (MAX_OFFSET),
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .QW          (QW)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .decay  (decay_ff),
      .len_m  (len_m),
      .len_l  (len_l),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   // decouples sample intake from the slow divide
   deconv_queue #(
      .WIDTH (QW),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .valid     (q_valid)
   );

   // back: stages two and three, divide, result beat
   deconv_back #(
      .MAX_OFFSET  (MAX_OFFSET),
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .QW          (QW)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_rdata),
      .q_pop   (q_pop),
      .len_l   (len_l),
      .rsp_if  (rsp_if)
   );

endmodule

// ===== tb/tb_moving_window_deconvolution_core.sv =====
// self-checking testbench of the moving window deconvolution core
module tb_moving_window_deconvolution_core;
   import deconv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = 1024;
   localparam int WATCHDOG_MAX  = 20000;
   localparam int SETTLE_CYCLES = 300;
   localparam int RANDOM_ITEMS  = 900;

   // filter model with its own copy of registers and state, plus the queue
   // of filtered values still owed by the block
   class deconv_scoreboard;
      logic [DECAY_BITS-1:0]   decay;
      logic [LEN_BITS-1:0]     offset_len;
      logic [LEN_BITS-1:0]     window_len;
      longint                  prev_x;
      longint                  acc;
      longint                  acc_hist[DEPTH];
      longint                  diff_hist[DEPTH];
      logic signed [TOTAL_BITS-1:0] total;
      int unsigned             seen;
      int unsigned             acc_pos;
      int unsigned             diff_pos;
      logic signed [48:0]      owed[$];
      int                      errors;
      int                      checked;
      int                      samples;

      function new();
         decay = DECAY_RESET;
         offset_len = LEN_RESET;
         window_len = LEN_RESET;
         prev_x = 0;
         acc = 0;
         total = '0;
         seen = 0;
         acc_pos = 0;
         diff_pos = 0;
         errors = 0;
         checked = 0;
         samples = 0;
         foreach (acc_hist[i]) acc_hist[i] = 0;
         foreach (diff_hist[i]) diff_hist[i] = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_DECAY: begin
               decay = val[DECAY_BITS-1:0];
            end
            CSR_OFFSET: begin
               offset_len = val[LEN_BITS-1:0];
            end
            CSR_WINDOW: begin
               window_len = val[LEN_BITS-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function int unsigned clamp_len(logic [LEN_BITS-1:0] v);
         if (v == 0) return 1;
         if (v > DEPTH) return DEPTH;
         return v;
      endfunction

      // one accepted sample beat through all three stages
      function void note_sample(logic signed [15:0] x, logic first);
         longint xs, a, delayed, d, hi_lim, lo_lim;
         int unsigned n, m, l;
         logic signed [TOTAL_BITS-1:0] t;
         longint q;
         m = clamp_len(offset_len);
         l = clamp_len(window_len);
         hi_lim = (longint'(1) <<< 47) - 1;
         lo_lim = -hi_lim - 1;
         samples++;
         if (first) begin
            prev_x = 0;
            acc = 0;
            total = '0;
            seen = 0;
            acc_pos = 0;
            diff_pos = 0;
         end
         n = seen;
         xs = x;
         a = xs * 65536 - longint'(decay) * prev_x + acc;
         if (a > hi_lim) a = hi_lim;
         if (a < lo_lim) a = lo_lim;
         acc = a;
         prev_x = xs;
         delayed = acc_hist[(acc_pos + DEPTH - m) % DEPTH];
         acc_hist[acc_pos] = a;
         acc_pos = (acc_pos + 1) % DEPTH;
         if (seen < SEEN_MAX) seen++;
         if (n < m) return;
         d = a - delayed;
         t = total + TOTAL_BITS'(d);
         if (n >= m + l) t = t - TOTAL_BITS'(diff_hist[(diff_pos + DEPTH - l) % DEPTH]);
         total = t;
         diff_hist[diff_pos] = d;
         diff_pos = (diff_pos + 1) % DEPTH;
         if (n + 1 < m + l) return;
         q = longint'(total) / longint'(l);
         owed.push_back(q[48:0]);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic signed [48:0] got);
         logic signed [48:0] want;
         if (owed.size() == 0) begin
            report($sformatf("unexpected filtered_value %0d", got));
            return;
         end
         want = owed.pop_front();
         checked++;
         if (got !== want)
            report($sformatf("filtered_value %0d, expected %0d", got, want));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   deconv_req_if #(.SAMPLE_BITS(16)) req_if ();
   deconv_rsp_if #(.SAMPLE_BITS(16)) rsp_if ();

   moving_window_deconvolution_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if.sink),
      .rsp_if           (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   deconv_scoreboard sb = new();

   int snd_idle_pct;   // chance in percent that the sender skips a cycle
   int rcv_idle_pct;   // chance in percent that the receiver stalls
   int quiet_cycles;
   int waveforms;
   int configs_used;

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // monitor: predict on every accepted sample beat, check every result beat,
   // and stop the run if nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            sb.note_sample(req_if.sample_value, req_if.first_of_waveform);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_result(rsp_if.filtered_value);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("watchdog expired with %0d results outstanding", sb.owed.size());
            $display("FAIL moving_window_deconvolution_core");
            $finish;
         end
      end
   end

   // one sample beat; valid stays high so back-to-back beats need no re-raise
   task automatic send_sample(logic signed [15:0] x, logic first);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid             <= 1'b1;
      req_if.sample_value      <= x;
      req_if.first_of_waveform <= first;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // hold off until every owed result is in and the back end has drained
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one write beat, then the write enable is driven low before the task returns
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      sb.set_reg(idx, val);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_filter(int f, int m, int l);
      wait_idle();
      write_reg(CSR_DECAY, CSR_DATA_BITS'(f));
      write_reg(CSR_OFFSET, CSR_DATA_BITS'(m));
      write_reg(CSR_WINDOW, CSR_DATA_BITS'(l));
      configs_used++;
   endtask

   // mostly uniform samples, with the rails and small values near zero now and then
   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // one waveform of len beats; a few stray start flags break the sequence
   task automatic send_waveform(int len);
      logic stray;
      waveforms++;
      send_sample(pick_sample(), 1'b1);
      for (int i = 1; i < len; i++) begin
         stray = ($urandom_range(99) < 3);
         send_sample(pick_sample(), stray);
      end
   endtask

   task automatic random_phase(int items);
      int f, m, l, eff_m, eff_l, len, done;
      done = 0;
      while (done < items) begin
         case ($urandom_range(3))
            0: f = 0;
            1: f = 65536;
            2: f = 131071;
            default: f = $urandom_range(70000);
         endcase
         // small lengths mostly, zero now and then
         m = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
         l = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
         set_filter(f, m, l);
         eff_m = (m == 0) ? 1 : m;
         eff_l = (l == 0) ? 1 : l;
         repeat ($urandom_range(1, 3)) begin
            len = eff_m + eff_l + $urandom_range(0, 20);
            send_waveform(len);
            done += len;
         end
         // decay change in the middle of a waveform, lengths untouched
         if ($urandom_range(3) == 0) begin
            wait_idle();
            write_reg(CSR_DECAY, CSR_DATA_BITS'($urandom_range(131071)));
            repeat (5) send_sample(pick_sample(), 1'b0);
            done += 5;
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.sample_value <= '0;
      req_if.first_of_waveform <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_DECAY;
      csr_write_data   <= '0;
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      quiet_cycles = 0;
      waveforms = 0;
      configs_used = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, no start flag: rails, zero and minus one
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'shffff, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      // fresh waveform under unity decay
      send_sample(16'sh0100, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      // zero decay, window of 3 with negative totals to check truncation
      set_filter(0, 2, 3);
      send_sample(-16'sd7, 1'b1);
      for (int i = 0; i < 7; i++) send_sample(16'(i * 3 - 11), 1'b0);
      // decay above unity, zero lengths acting as one
      set_filter(131071, 0, 0);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);

      // three idling patterns
      snd_idle_pct = 28;
      rcv_idle_pct = 75;
      random_phase(RANDOM_ITEMS / 3);
      snd_idle_pct = 75;
      rcv_idle_pct = 28;
      random_phase(RANDOM_ITEMS / 3);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      random_phase(RANDOM_ITEMS / 3);

      wait_idle();
      $display("covered %0d samples in %0d waveforms over %0d filter settings",
               sb.samples, waveforms, configs_used);
      $display("checked %0d filtered values, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("PASS moving_window_deconvolution_core");
      end else begin
         $display("FAIL moving_window_deconvolution_core");
      end
      $finish;
   end

endmodule
